// File: hw/rtl/edp_pkg.sv
package edp_pkg;

    localparam int MAX_BIT_RATE    = 2048;
    localparam int RATE_W          = 12;
    localparam int LEVEL_W         = 2;
    localparam int MASK_W          = 32;
    localparam int MASK_SH_W       = $clog2(MASK_W);
    localparam int TAIL_W          = 24;
    localparam int TAIL_LEN        = 24;
    localparam int BLOCK_LEN       = 128;
    localparam int BLOCK_W         = 11;
    localparam int PIB_W           = $clog2(BLOCK_LEN);
    localparam int POS_W           = 18;
    localparam int SOFT_W          = 8;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // register values after reset
    localparam int BIT_RATE_RST   = 32;
    localparam int LEN_FIRST_RST  = 6 * (BIT_RATE_RST / 8) - 3;
    localparam int LEN_SECOND_RST = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BIT_RATE    = 3'd0,
        CFG_PROT_LEVEL  = 3'd1,
        CFG_PROFILE_B   = 3'd2,
        CFG_MASK_FIRST  = 3'd3,
        CFG_MASK_SECOND = 3'd4,
        CFG_MASK_TAIL   = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        SEG_FIRST  = 2'd0,
        SEG_SECOND = 2'd1,
        SEG_TAIL   = 2'd2
    } seg_t;

    typedef struct packed {
        seg_t               seg;
        logic [BLOCK_W-1:0] block_count;
        logic [PIB_W-1:0]   position_in_block;
        logic [POS_W-1:0]   position_counter;
    } walk_t;

    localparam walk_t WALK_ORIGIN = '{
        seg:               SEG_FIRST,
        block_count:       '0,
        position_in_block: '0,
        position_counter:  '0
    };

    typedef enum logic [1:0] {
        HOP_FOUND = 2'd0,
        HOP_MOVED = 2'd1,
        HOP_END   = 2'd2
    } hop_kind_t;

    typedef struct packed {
        hop_kind_t kind;
        walk_t     w;
    } hop_t;

    typedef enum logic [1:0] {
        ST_SEEK  = 2'd0,
        ST_READY = 2'd1,
        ST_LOOK  = 2'd2,
        ST_EMPTY = 2'd3
    } walk_state_t;

    typedef struct packed {
        logic               restart;
        logic [BLOCK_W-1:0] len_first;
        logic [BLOCK_W-1:0] len_second;
        logic [MASK_W-1:0]  mask_first;
        logic [MASK_W-1:0]  mask_second;
        logic [TAIL_W-1:0]  mask_tail;
    } cfg_t;

endpackage

// File: hw/rtl/eep_depuncture_address_gen_top.sv
// EEP depuncture address generator: each received soft bit comes in as one item and leaves
// with the mother-code position it belongs to in the Viterbi block, and frame_last set on the
// final kept position of a frame (L1 blocks under mask_first, L2 blocks under mask_second,
// then a 24-position tail under mask_tail), or on every item at position 0 when a frame keeps
// no position. In steady state, while the output is not stalled, one item is taken and one
// result given per clock; the position walker moves one hop per cycle, and a hop ends at the
// next kept position, so each item takes a single hop while the next kept position lies in
// the current or following 128-position block. Crossing into the next segment, skipping a
// segment whose mask is all zero, or reaching the tail adds a hop for each segment passed,
// and the first item of each new frame waits while the walker seeks from the frame start.
// After a register write the walker rescans from its current place; the lengths follow
// bit_rate, profile_b and protection_level via the length registers. A two-entry input queue
// and an output register let one side stall without stopping the other, up to a full queue.
module eep_depuncture_address_gen_top
    import edp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     soft_valid,
    output logic                     soft_ready,
    input  logic signed [SOFT_W-1:0] soft_bit,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [POS_W-1:0]         block_position,
    output logic signed [SOFT_W-1:0] soft_out,
    output logic                     frame_last,
    input  logic                     cfg_write_en,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    cfg_t              cfg;
    logic              q_valid;
    logic              q_pop;
    logic [SOFT_W-1:0] q_data;
    logic [SOFT_W-1:0] soft_bits;

    assign soft_bits = soft_bit;

    edp_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    edp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (soft_valid),
        .push_ready (soft_ready),
        .push_data  (soft_bits),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    edp_walk u_walk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .block_position (block_position),
        .soft_out       (soft_out),
        .frame_last     (frame_last)
    );

endmodule

// File: hw/rtl/edp_cfg.sv
module edp_cfg
    import edp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    localparam int NA_W       = $clog2(MAX_BIT_RATE / 8 + 1);
    localparam int NB_W       = $clog2(MAX_BIT_RATE / 32 + 1);
    localparam int LEN_CALC_W = BLOCK_W + 1;

    localparam logic [LEVEL_W-1:0] LEVEL_2 = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_4 = 2'd3;

    logic [RATE_W-1:0]     bit_rate_reg;
    logic [LEVEL_W-1:0]    level_reg;
    logic                  profile_b_reg;
    logic [MASK_W-1:0]     mask_first_reg;
    logic [MASK_W-1:0]     mask_second_reg;
    logic [TAIL_W-1:0]     mask_tail_reg;
    logic [BLOCK_W-1:0]    len_first_reg;
    logic [BLOCK_W-1:0]    len_first_next;
    logic [BLOCK_W-1:0]    len_second_reg;
    logic [BLOCK_W-1:0]    len_second_next;
    logic                  write_d_reg;

    logic [RATE_W-1:0]     rate;
    logic [NA_W-1:0]       n_a;
    logic [NB_W-1:0]       n_b;
    logic [LEN_CALC_W-1:0] na_x;
    logic [LEN_CALC_W-1:0] nb_x;

    function automatic logic [BLOCK_W-1:0] minus3(input logic [LEN_CALC_W-1:0] x);
        logic [LEN_CALC_W-1:0] d;
        d = x - LEN_CALC_W'(3);
        return (x >= LEN_CALC_W'(3)) ? d[BLOCK_W-1:0] : '0;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_rate_reg    <= RATE_W'(BIT_RATE_RST);
            level_reg       <= '0;
            profile_b_reg   <= 1'b0;
            mask_first_reg  <= '1;
            mask_second_reg <= '1;
            mask_tail_reg   <= '1;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BIT_RATE:    bit_rate_reg    <= cfg_data[RATE_W-1:0];
                CFG_PROT_LEVEL:  level_reg       <= cfg_data[LEVEL_W-1:0];
                CFG_PROFILE_B:   profile_b_reg   <= cfg_data[0];
                CFG_MASK_FIRST:  mask_first_reg  <= cfg_data[MASK_W-1:0];
                CFG_MASK_SECOND: mask_second_reg <= cfg_data[MASK_W-1:0];
                CFG_MASK_TAIL:   mask_tail_reg   <= cfg_data[TAIL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // segment lengths in blocks of 128 positions
    always_comb
    begin
        rate = (bit_rate_reg > RATE_W'(MAX_BIT_RATE)) ? RATE_W'(MAX_BIT_RATE) : bit_rate_reg;
        n_a  = NA_W'(rate >> 3);
        n_b  = NB_W'(rate >> 5);
        na_x = LEN_CALC_W'(n_a);
        nb_x = LEN_CALC_W'(n_b);
        if (profile_b_reg)
        begin
            len_first_next  = minus3((nb_x << 4) + (nb_x << 3));
            len_second_next = BLOCK_W'(3);
        end
        else
        begin
            unique case (level_reg)
                LEVEL_2:
                begin
                    if (n_a == NA_W'(1))
                    begin
                        len_first_next  = BLOCK_W'(5);
                        len_second_next = BLOCK_W'(1);
                    end
                    else
                    begin
                        len_first_next  = minus3(na_x << 1);
                        len_second_next = BLOCK_W'((na_x << 2) + LEN_CALC_W'(3));
                    end
                end
                LEVEL_4:
                begin
                    len_first_next  = minus3(na_x << 2);
                    len_second_next = BLOCK_W'((na_x << 1) + LEN_CALC_W'(3));
                end
                default:
                begin
                    len_first_next  = minus3((na_x << 2) + (na_x << 1));
                    len_second_next = BLOCK_W'(3);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_first_reg  <= BLOCK_W'(LEN_FIRST_RST);
            len_second_reg <= BLOCK_W'(LEN_SECOND_RST);
            write_d_reg    <= 1'b0;
        end
        else
        begin
            len_first_reg  <= len_first_next;
            len_second_reg <= len_second_next;
            write_d_reg    <= cfg_write_en;
        end
    end

    // lengths settle in the length registers after a write, so the walker restarts twice
    assign cfg.restart     = cfg_write_en | write_d_reg;
    assign cfg.len_first   = len_first_reg;
    assign cfg.len_second  = len_second_reg;
    assign cfg.mask_first  = mask_first_reg;
    assign cfg.mask_second = mask_second_reg;
    assign cfg.mask_tail   = mask_tail_reg;

endmodule

// File: hw/rtl/edp_fifo.sv
module edp_fifo
    import edp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [SOFT_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop,
    output logic [SOFT_W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [SOFT_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/edp_walk.sv
module edp_walk
    import edp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     q_valid,
    input  logic [SOFT_W-1:0]        q_data,
    output logic                     q_pop,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [POS_W-1:0]         block_position,
    output logic signed [SOFT_W-1:0] soft_out,
    output logic                     frame_last
);

    walk_state_t              state_reg;
    walk_state_t              state_next;
    walk_t                    cur_reg;
    walk_t                    cur_next;
    walk_t                    raw_reg;
    walk_t                    raw_next;
    logic                     from_origin_reg;
    logic                     from_origin_next;
    logic [POS_W-1:0]         pend_pos_reg;
    logic [POS_W-1:0]         pend_pos_next;
    logic                     res_valid_reg;
    logic                     res_valid_next;
    logic [POS_W-1:0]         pos_reg;
    logic signed [SOFT_W-1:0] soft_reg;
    logic                     last_reg;

    walk_t                    hop_in;
    hop_t                     hop_res;
    logic                     can_load;
    logic                     emit;
    logic [POS_W-1:0]         emit_pos;
    logic                     emit_last;

    function automatic logic [MASK_SH_W-1:0] first_set(input logic [MASK_W-1:0] v);
        logic [MASK_SH_W-1:0] idx;
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = MASK_SH_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic walk_t advance(input walk_t w);
        walk_t a;
        a = w;
        a.position_counter  = w.position_counter + 1'b1;
        a.position_in_block = w.position_in_block + 1'b1;
        if (w.seg != SEG_TAIL && w.position_in_block == PIB_W'(BLOCK_LEN - 1))
        begin
            a.position_in_block = '0;
            a.block_count       = w.block_count + 1'b1;
        end
        return a;
    endfunction

    // one hop: next kept position within reach, the start of the next segment, or the frame end
    function automatic hop_t hop_step(input walk_t w, input cfg_t c);
        logic [BLOCK_W-1:0]   len;
        logic [MASK_W-1:0]    mask;
        logic [2*MASK_W-1:0]  dbl;
        logic [MASK_W-1:0]    lim;
        logic [MASK_W-1:0]    hit;
        logic [TAIL_W-1:0]    thit;
        logic [MASK_SH_W-1:0] d;
        logic [MASK_SH_W-1:0] f;
        logic [BLOCK_W-1:0]   bc_inc;
        logic [POS_W-1:0]     step;
        hop_t                 r;
        r.kind = HOP_END;
        r.w    = w;
        step   = '0;
        len    = (w.seg == SEG_FIRST) ? c.len_first : c.len_second;
        mask   = (w.seg == SEG_FIRST) ? c.mask_first : c.mask_second;
        bc_inc = w.block_count + 1'b1;
        dbl    = {mask, mask} >> w.position_in_block[MASK_SH_W-1:0];
        // last 32 positions of a block: do not look past the block end
        lim    = (w.position_in_block[PIB_W-1:MASK_SH_W] == '1)
               ? ({MASK_W{1'b1}} >> w.position_in_block[MASK_SH_W-1:0]) : '1;
        hit    = dbl[MASK_W-1:0] & lim;
        d      = first_set(hit);
        f      = first_set(mask);
        thit   = c.mask_tail >> w.position_in_block[MASK_SH_W-1:0];
        unique case (w.seg)
            SEG_FIRST, SEG_SECOND:
            begin
                if (w.block_count >= len || mask == '0 || (!(|hit) && bc_inc >= len))
                begin
                    r.kind                = HOP_MOVED;
                    r.w.seg               = (w.seg == SEG_FIRST) ? SEG_SECOND : SEG_TAIL;
                    r.w.block_count       = '0;
                    r.w.position_in_block = '0;
                    if (w.block_count >= len)
                    begin
                        step = '0;
                    end
                    else if (mask == '0)
                    begin
                        // whole rest of the segment is punctured
                        step = POS_W'({len - w.block_count, {PIB_W{1'b0}}})
                             - POS_W'(w.position_in_block);
                    end
                    else
                    begin
                        step = POS_W'(BLOCK_LEN) - POS_W'(w.position_in_block);
                    end
                end
                else if (|hit)
                begin
                    r.kind                = HOP_FOUND;
                    r.w.position_in_block = w.position_in_block + PIB_W'(d);
                    step                  = POS_W'(d);
                end
                else
                begin
                    r.kind                = HOP_FOUND;
                    r.w.block_count       = bc_inc;
                    r.w.position_in_block = PIB_W'(f);
                    step = POS_W'(BLOCK_LEN) - POS_W'(w.position_in_block) + POS_W'(f);
                end
            end
            SEG_TAIL:
            begin
                if (w.position_in_block < PIB_W'(TAIL_LEN) && (|thit))
                begin
                    r.kind                = HOP_FOUND;
                    d                     = first_set(MASK_W'(thit));
                    r.w.position_in_block = w.position_in_block + PIB_W'(d);
                    step                  = POS_W'(d);
                end
            end
            default:
            begin
                r.kind = HOP_END;
            end
        endcase
        r.w.position_counter = w.position_counter + step;
        return r;
    endfunction

    assign can_load = !res_valid_reg || result_ready;
    assign hop_in   = (state_reg == ST_READY) ? advance(cur_reg) : cur_reg;
    assign hop_res  = hop_step(hop_in, cfg);
    assign q_pop    = emit;

    always_comb
    begin
        state_next = state_reg;
        if (cfg.restart)
        begin
            state_next = ST_SEEK;
        end
        else
        begin
            unique case (state_reg)
                ST_SEEK:
                begin
                    if (hop_res.kind == HOP_FOUND)
                    begin
                        state_next = ST_READY;
                    end
                    else if (hop_res.kind == HOP_END && from_origin_reg)
                    begin
                        state_next = ST_EMPTY;
                    end
                end
                ST_READY:
                begin
                    if (q_valid && can_load)
                    begin
                        unique case (hop_res.kind)
                            HOP_FOUND: state_next = ST_READY;
                            HOP_MOVED: state_next = ST_LOOK;
                            default:   state_next = ST_SEEK;
                        endcase
                    end
                end
                ST_LOOK:
                begin
                    if (can_load)
                    begin
                        unique case (hop_res.kind)
                            HOP_FOUND: state_next = ST_READY;
                            HOP_MOVED: state_next = ST_LOOK;
                            default:   state_next = ST_SEEK;
                        endcase
                    end
                end
                ST_EMPTY:
                begin
                    state_next = ST_EMPTY;
                end
            endcase
        end
    end

    always_comb
    begin
        cur_next         = cur_reg;
        raw_next         = raw_reg;
        from_origin_next = from_origin_reg;
        pend_pos_next    = pend_pos_reg;
        emit             = 1'b0;
        emit_pos         = cur_reg.position_counter;
        emit_last        = 1'b0;
        if (cfg.restart)
        begin
            // resume from where the frame really stands
            cur_next         = raw_reg;
            from_origin_next = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_SEEK:
                begin
                    if (hop_res.kind == HOP_FOUND || hop_res.kind == HOP_MOVED)
                    begin
                        cur_next = hop_res.w;
                    end
                    else
                    begin
                        cur_next         = WALK_ORIGIN;
                        from_origin_next = 1'b1;
                    end
                end
                ST_READY, ST_LOOK:
                begin
                    if (can_load && (state_reg == ST_LOOK || q_valid))
                    begin
                        if (state_reg == ST_READY)
                        begin
                            raw_next      = hop_in;
                            pend_pos_next = cur_reg.position_counter;
                        end
                        else
                        begin
                            emit_pos = pend_pos_reg;
                        end
                        unique case (hop_res.kind)
                            HOP_FOUND:
                            begin
                                emit     = q_valid;
                                cur_next = hop_res.w;
                            end
                            HOP_MOVED:
                            begin
                                cur_next = hop_res.w;
                            end
                            default:
                            begin
                                // last kept position of the frame
                                emit             = q_valid;
                                emit_last        = 1'b1;
                                cur_next         = WALK_ORIGIN;
                                raw_next         = WALK_ORIGIN;
                                from_origin_next = 1'b1;
                            end
                        endcase
                    end
                end
                ST_EMPTY:
                begin
                    if (q_valid && can_load)
                    begin
                        emit      = 1'b1;
                        emit_pos  = '0;
                        emit_last = 1'b1;
                        raw_next  = WALK_ORIGIN;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SEEK;
            cur_reg         <= WALK_ORIGIN;
            raw_reg         <= WALK_ORIGIN;
            from_origin_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_reg         <= cur_next;
            raw_reg         <= raw_next;
            from_origin_reg <= from_origin_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_pos_reg <= pend_pos_next;
        if (emit)
        begin
            pos_reg  <= emit_pos;
            soft_reg <= $signed(q_data);
            last_reg <= emit_last;
        end
    end

    assign result_valid   = res_valid_reg;
    assign block_position = pos_reg;
    assign soft_out       = soft_reg;
    assign frame_last     = last_reg;

endmodule

// File: dv/edp_placement_checker.sv
`timescale 1ns / 100ps

module edp_placement_checker
    import edp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     soft_valid,
    input  logic                     soft_ready,
    input  logic signed [SOFT_W-1:0] soft_bit,
    input  logic                     result_valid,
    input  logic                     result_ready,
    input  logic [POS_W-1:0]         block_position,
    input  logic signed [SOFT_W-1:0] soft_out,
    input  logic                     frame_last,
    input  logic                     cfg_write_en,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    output int                       mismatch_count,
    output int                       outstanding,
    output int                       frames_done
);

    localparam logic [LEVEL_W-1:0] LEVEL_A2 = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_A4 = 2'd3;

    // counters are wider than the block's own so the wrap tests stay visible
    typedef struct packed {
        seg_t               seg;
        logic [BLOCK_W:0]   blk;
        logic [7:0]         pib;
        logic [POS_W-1:0]   pos;
    } cursor_t;

    typedef struct packed {
        logic [POS_W-1:0]         pos;
        logic signed [SOFT_W-1:0] soft_val;
        logic                     last;
    } placement_t;

    localparam cursor_t CURSOR_START = '{seg: SEG_FIRST, blk: '0, pib: '0, pos: '0};

    logic [RATE_W-1:0]  rate_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               prof_b_reg;
    logic [MASK_W-1:0]  mask1_reg;
    logic [MASK_W-1:0]  mask2_reg;
    logic [TAIL_W-1:0]  mask_t_reg;
    cursor_t            walk;
    placement_t         placement_q[$];
    placement_t         got;
    placement_t         want;

    function automatic int unsigned nonneg(input int v);
        return (v < 0) ? 0 : v;
    endfunction

    function automatic void segment_lengths(output int unsigned len1, output int unsigned len2);
        int rate_c;
        int n;
        rate_c = (rate_reg > MAX_BIT_RATE) ? MAX_BIT_RATE : int'(rate_reg);
        if (prof_b_reg)
        begin
            n = rate_c / 32;
            len1 = nonneg(24 * n - 3);
            len2 = 3;
        end
        else
        begin
            n = rate_c / 8;
            case (level_reg)
                LEVEL_A2:
                begin
                    // the low-rate exception of the second A level
                    if (n == 1)
                    begin
                        len1 = 5;
                        len2 = 1;
                    end
                    else
                    begin
                        len1 = nonneg(2 * n - 3);
                        len2 = nonneg(4 * n + 3);
                    end
                end
                LEVEL_A4:
                begin
                    len1 = nonneg(4 * n - 3);
                    len2 = nonneg(2 * n + 3);
                end
                default:
                begin
                    len1 = nonneg(6 * n - 3);
                    len2 = 3;
                end
            endcase
        end
    endfunction

    function automatic cursor_t step_cursor(input cursor_t c);
        c.pos = c.pos + 1'b1;
        c.pib = c.pib + 1'b1;
        if ((c.seg == SEG_FIRST || c.seg == SEG_SECOND) && c.pib >= BLOCK_LEN)
        begin
            c.pib = '0;
            c.blk = c.blk + 1'b1;
        end
        return c;
    endfunction

    // walks c forward to the next kept position, 0 when the frame has none left
    function automatic bit find_kept(inout cursor_t c, input int unsigned len1,
                                     input int unsigned len2);
        int unsigned       seg_len;
        logic [MASK_W-1:0] seg_mask;
        logic [31:0]       jump;
        bit                searching;
        bit                found;
        searching = 1'b1;
        found = 1'b0;
        while (searching)
        begin
            if (c.seg == SEG_FIRST || c.seg == SEG_SECOND)
            begin
                seg_len  = (c.seg == SEG_FIRST) ? len1 : len2;
                seg_mask = (c.seg == SEG_FIRST) ? mask1_reg : mask2_reg;
                if (c.blk >= seg_len || seg_mask == '0)
                begin
                    if (c.blk < seg_len)
                    begin
                        // empty mask: jump the counter over the rest of the segment
                        jump = 32'(c.pos) + (seg_len - c.blk) * BLOCK_LEN - c.pib;
                        c.pos = jump[POS_W-1:0];
                    end
                    c.seg = (c.seg == SEG_FIRST) ? SEG_SECOND : SEG_TAIL;
                    c.blk = '0;
                    c.pib = '0;
                end
                else if (seg_mask[c.pib[4:0]])
                begin
                    found = 1'b1;
                    searching = 1'b0;
                end
                else
                begin
                    c = step_cursor(c);
                end
            end
            else if (c.seg == SEG_TAIL)
            begin
                if (c.pib >= TAIL_LEN)
                begin
                    searching = 1'b0;
                end
                else if (mask_t_reg[c.pib[4:0]])
                begin
                    found = 1'b1;
                    searching = 1'b0;
                end
                else
                begin
                    c = step_cursor(c);
                end
            end
            else
            begin
                searching = 1'b0;
            end
        end
        return found;
    endfunction

    function automatic placement_t place_soft_bit(input logic signed [SOFT_W-1:0] sb);
        int unsigned len1;
        int unsigned len2;
        cursor_t     probe;
        placement_t  r;
        segment_lengths(len1, len2);
        r.soft_val = sb;
        if (!find_kept(walk, len1, len2))
        begin
            walk = CURSOR_START;
        end
        if (!find_kept(walk, len1, len2))
        begin
            // nothing kept anywhere in the frame
            walk = CURSOR_START;
            r.pos = '0;
            r.last = 1'b1;
        end
        else
        begin
            r.pos = walk.pos;
            walk = step_cursor(walk);
            probe = walk;
            r.last = !find_kept(probe, len1, len2);
            if (r.last)
            begin
                walk = CURSOR_START;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   = RATE_W'(BIT_RATE_RST);
            level_reg  = '0;
            prof_b_reg = 1'b0;
            mask1_reg  = '1;
            mask2_reg  = '1;
            mask_t_reg = '1;
            walk       = CURSOR_START;
            placement_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_BIT_RATE:    rate_reg   = cfg_data[RATE_W-1:0];
                    CFG_PROT_LEVEL:  level_reg  = cfg_data[LEVEL_W-1:0];
                    CFG_PROFILE_B:   prof_b_reg = cfg_data[0];
                    CFG_MASK_FIRST:  mask1_reg  = cfg_data[MASK_W-1:0];
                    CFG_MASK_SECOND: mask2_reg  = cfg_data[MASK_W-1:0];
                    CFG_MASK_TAIL:   mask_t_reg = cfg_data[TAIL_W-1:0];
                    default: ;
                endcase
            end
            if (soft_valid && soft_ready)
            begin
                placement_q.push_back(place_soft_bit(soft_bit));
            end
            if (result_valid && result_ready)
            begin
                got = '{pos: block_position, soft_val: soft_out, last: frame_last};
                if (placement_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result: position %0d soft %0d last %0b",
                             $time, got.pos, got.soft_val, got.last);
                end
                else
                begin
                    want = placement_q.pop_front();
                    if (got.pos !== want.pos)
                    begin
                        mismatch_count++;
                        $display("%0t: block_position expected %0d actual %0d",
                                 $time, want.pos, got.pos);
                    end
                    if (got.soft_val !== want.soft_val)
                    begin
                        mismatch_count++;
                        $display("%0t: soft_out expected %0d actual %0d",
                                 $time, want.soft_val, got.soft_val);
                    end
                    if (got.last !== want.last)
                    begin
                        mismatch_count++;
                        $display("%0t: frame_last expected %0b actual %0b",
                                 $time, want.last, got.last);
                    end
                end
                if (got.last === 1'b1)
                begin
                    frames_done++;
                end
            end
            outstanding <= placement_q.size();
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import edp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int CFG_SETTLE    = 8;
    localparam int SETTINGS_EACH = 7;
    localparam int BITS_EACH     = 84;
    localparam int DRAIN_CYCLES  = 20;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     soft_valid = 1'b0;
    logic                     soft_ready;
    logic signed [SOFT_W-1:0] soft_bit = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    logic [POS_W-1:0]         block_position;
    logic signed [SOFT_W-1:0] soft_out;
    logic                     frame_last;
    logic                     cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    int mismatch_count;
    int outstanding;
    int frames_done;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bits_sent = 0;
    int settings_done = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    eep_depuncture_address_gen_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .soft_valid     (soft_valid),
        .soft_ready     (soft_ready),
        .soft_bit       (soft_bit),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .block_position (block_position),
        .soft_out       (soft_out),
        .frame_last     (frame_last),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    edp_placement_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .soft_valid     (soft_valid),
        .soft_ready     (soft_ready),
        .soft_bit       (soft_bit),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .block_position (block_position),
        .soft_out       (soft_out),
        .frame_last     (frame_last),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .frames_done    (frames_done)
    );

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_ready <= 1'b0;
        end
        else begin
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_soft(input logic signed [SOFT_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            soft_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        soft_valid <= 1'b1;
        soft_bit <= value;
        do @(posedge clk); while (!soft_ready);
        bits_sent++;
    endtask

    task automatic drain();
        soft_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic apply_setting(input logic [RATE_W-1:0] rate, input logic [LEVEL_W-1:0] level,
                                 input logic prof, input logic [MASK_W-1:0] m1,
                                 input logic [MASK_W-1:0] m2, input logic [TAIL_W-1:0] mt);
        cfg_index_t            idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        idx = '{CFG_BIT_RATE, CFG_PROT_LEVEL, CFG_PROFILE_B,
                CFG_MASK_FIRST, CFG_MASK_SECOND, CFG_MASK_TAIL};
        val = '{CFG_DATA_W'(rate), CFG_DATA_W'(level), CFG_DATA_W'(prof),
                CFG_DATA_W'(m1), CFG_DATA_W'(m2), CFG_DATA_W'(mt)};
        for (int k = 0; k < 6; k++) begin
            @(posedge clk);
            cfg_write_en <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
        end
        @(posedge clk);
        cfg_write_en <= 1'b0;
        // let the walker rescan before the next item
        repeat (CFG_SETTLE) @(posedge clk);
        settings_done++;
    endtask

    // mostly sparse masks so that frames end often
    function automatic logic [MASK_W-1:0] pick_mask(input int width);
        logic [MASK_W-1:0] m;
        case ($urandom_range(9))
            0: m = '0;
            1: m = '1;
            2, 3: m = $urandom();
            default: begin
                m = '0;
                repeat ($urandom_range(1, 3)) m[$urandom_range(width - 1)] = 1'b1;
            end
        endcase
        if (width < MASK_W) begin
            m = m & ((32'd1 << width) - 1);
        end
        return m;
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return RATE_W'($urandom_range(40));
            6, 7: return RATE_W'($urandom_range(41, 300));
            8: return $urandom_range(1) ? RATE_W'(MAX_BIT_RATE) : '1;
            default: return RATE_W'($urandom_range(4095));
        endcase
    endfunction

    initial begin
        int send_pct [3];
        int recv_pct [3];
        send_pct = '{24, 59, 0};
        recv_pct = '{59, 24, 0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, soft value extremes
        send_soft(-8'sd128);
        send_soft(8'sd127);
        send_soft(8'sd0);
        send_soft(-8'sd1);
        drain();
        // nothing kept in the whole frame
        apply_setting(RATE_W'(32), 2'd0, 1'b0, '0, '0, '0);
        send_soft(8'sh55);
        send_soft(-8'sh56);
        drain();
        // low-rate exception of the second A level, remainder dropped
        apply_setting(RATE_W'(12), 2'd1, 1'b0, '0, '0, 24'h800001);
        send_soft(8'sd3);
        send_soft(-8'sd3);
        send_soft(8'sd64);
        drain();
        // rate above the maximum, B profile
        apply_setting('1, 2'd0, 1'b1, '0, 32'h0000_0001, '0);
        send_soft(8'sd1);
        send_soft(8'sd2);
        send_soft(-8'sd100);
        drain();
        // rate below one unit: first length negative, clamped to zero
        apply_setting(RATE_W'(5), 2'd3, 1'b0, '1, 32'h8000_0000, 24'h000001);
        send_soft(8'sd10);
        send_soft(8'sd20);
        send_soft(8'sd30);
        send_soft(8'sd40);
        drain();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = send_pct[mode];
            recv_idle_pct = recv_pct[mode];
            for (int s = 0; s < SETTINGS_EACH; s++) begin
                apply_setting(pick_rate(), LEVEL_W'($urandom_range(3)), 1'($urandom_range(1)),
                              pick_mask(MASK_W), pick_mask(MASK_W), TAIL_W'(pick_mask(TAIL_W)));
                repeat (BITS_EACH) send_soft(SOFT_W'($urandom_range(255)));
                drain();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d soft bits under %0d register settings, %0d frame ends",
                 bits_sent, settings_done, frames_done);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end
        else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
